// ----- rtl/core/lcar_pkg.sv -----
// Shared types and constants of the load-cell converter reader.
// Used by the controller, the datapath and the top level by scoped names.
package lcar_pkg;

    localparam int WEIGHT_W = 25;
    localparam int CAL_W    = 24;
    localparam int CNT_W    = 7;
    localparam int SUM_W    = 32;

    localparam logic [CAL_W-1:0] WEIGHT_MAX = 24'hFFFFFF;

    localparam logic       REQ_TICK  = 1'b0;
    localparam logic       REQ_START = 1'b1;

    localparam logic [1:0] MODE_READ = 2'd0;
    localparam logic [1:0] MODE_TARE = 2'd1;
    localparam logic [1:0] MODE_AVG  = 2'd2;
    localparam logic [1:0] MODE_RSV  = 2'd3;

    localparam logic       CFG_CAL     = 1'b0;
    localparam logic       CFG_SAMPLES = 1'b1;

    typedef struct packed {
        logic shift_clear;
        logic shift_en;
        logic shift_bit;
        logic tare_load;
        logic sum_clear;
        logic sum_add;
        logic div_start;
        logic div_avg;
    } t_dp_cmd;

    typedef struct packed {
        logic                div_done;
        logic [WEIGHT_W-1:0] weight;
        logic [CNT_W-1:0]    samples;
    } t_dp_status;

endpackage

// ----- rtl/core/lcar_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, sign and magnitude.
// Depends on lcar_pkg for the divisor width.
module lcar_div #(
    parameter int DIV_W = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DIV_W:0]            i_dividend,
    input  logic [lcar_pkg::CAL_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [DIV_W-1:0]          o_quot,
    output logic                      o_neg
);
    localparam int DW    = lcar_pkg::CAL_W;
    localparam int CNT_B = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_B-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [DIV_W-1:0] r_num;
    logic             r_neg;

    logic [DIV_W:0]   w_neg_div;
    logic [DIV_W-1:0] w_mag;
    logic [DW:0]      w_trial;
    logic [DW:0]      w_diff;
    logic             w_qbit;

    assign w_neg_div = (DIV_W+1)'(0) - i_dividend;
    assign w_mag     = i_dividend[DIV_W] ? w_neg_div[DIV_W-1:0] : i_dividend[DIV_W-1:0];
    assign w_trial   = {r_rem, r_num[DIV_W-1]};
    assign w_diff    = w_trial - {1'b0, r_den};
    assign w_qbit    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_B'(DIV_W);
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_num  <= w_mag;
                r_neg  <= i_dividend[DIV_W];
            end else if (r_busy) begin
                r_rem <= w_qbit ? w_diff[DW-1:0] : w_trial[DW-1:0];
                r_num <= {r_num[DIV_W-2:0], w_qbit};
                r_cnt <= r_cnt - CNT_B'(1);
                if (r_cnt == CNT_B'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_neg  = r_neg;

endmodule

// ----- rtl/core/lcar_datapath.sv -----
// Datapath: sample shifter, tare and sum registers, configuration, divider.
// Depends on lcar_pkg and lcar_div; driven by lcar_ctrl commands.
module lcar_datapath #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [lcar_pkg::CAL_W-1:0] i_cfg_data,
    input  lcar_pkg::t_dp_cmd          i_cmd,
    output lcar_pkg::t_dp_status       o_status
);
    localparam int DIV_W = (SAMPLE_BITS > lcar_pkg::SUM_W) ? SAMPLE_BITS : lcar_pkg::SUM_W;
    localparam int CW    = lcar_pkg::CAL_W;
    localparam int NW    = lcar_pkg::CNT_W;
    localparam int WW    = lcar_pkg::WEIGHT_W;
    localparam int SW    = lcar_pkg::SUM_W;

    logic [CW-1:0]          r_cal;
    logic [NW-1:0]          r_samples;
    logic [SAMPLE_BITS-1:0] r_shift;
    logic [SAMPLE_BITS-1:0] r_tare;
    logic signed [SW-1:0]   r_sum;

    logic [CW-1:0]          w_cal_eff;
    logic [NW-1:0]          w_samples_eff;
    logic [DIV_W:0]         w_dividend;
    logic [CW-1:0]          w_divisor;
    logic                   w_done;
    logic [DIV_W-1:0]       w_quot;
    logic                   w_neg;
    logic [CW-1:0]          w_mag;
    logic [WW-1:0]          w_weight;

    assign w_cal_eff     = (r_cal == '0) ? CW'(1) : r_cal;
    assign w_samples_eff = (r_samples == '0) ? NW'(1) : r_samples;

    always_comb begin
        if (i_cmd.div_avg) begin
            w_dividend = (DIV_W+1)'(r_sum);
            w_divisor  = CW'(w_samples_eff);
        end else begin
            w_dividend = (DIV_W+1)'({1'b0, r_shift}) - (DIV_W+1)'({1'b0, r_tare});
            w_divisor  = w_cal_eff;
        end
    end

    lcar_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_done),
        .o_quot     (w_quot),
        .o_neg      (w_neg)
    );

    assign w_mag    = (w_quot > DIV_W'(lcar_pkg::WEIGHT_MAX)) ? lcar_pkg::WEIGHT_MAX
                                                              : w_quot[CW-1:0];
    assign w_weight = w_neg ? (WW'(0) - {1'b0, w_mag}) : {1'b0, w_mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal     <= CW'(1);
            r_samples <= NW'(1);
            r_shift   <= '0;
            r_tare    <= '0;
            r_sum     <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lcar_pkg::CFG_CAL:     r_cal     <= i_cfg_data;
                    lcar_pkg::CFG_SAMPLES: r_samples <= i_cfg_data[NW-1:0];
                    default:               r_cal     <= r_cal;
                endcase
            end
            if (i_cmd.shift_clear) begin
                r_shift <= '0;
            end else if (i_cmd.shift_en) begin
                r_shift <= {r_shift[SAMPLE_BITS-2:0], i_cmd.shift_bit};
            end
            if (i_cmd.tare_load) begin
                r_tare <= r_shift;
            end
            if (i_cmd.sum_clear) begin
                r_sum <= '0;
            end else if (i_cmd.sum_add) begin
                r_sum <= r_sum + SW'(signed'(w_weight));
            end
        end
    end

    assign o_cfg_ready       = 1'b1;
    assign o_status.div_done = w_done;
    assign o_status.weight   = w_weight;
    assign o_status.samples  = w_samples_eff;

endmodule

// ----- rtl/core/lcar_ctrl.sv -----
// Controller: request handshake, converter phase sequencing, result register.
// Depends on lcar_pkg; commands lcar_datapath through t_dp_cmd.
module lcar_ctrl #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [1:0]                    i_mode,
    input  logic                          i_data_level,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_clock_level,
    output logic                          o_result_valid,
    output logic [lcar_pkg::WEIGHT_W-1:0] o_weight,
    output logic                          o_busy_res,
    output lcar_pkg::t_dp_cmd             o_cmd,
    input  lcar_pkg::t_dp_status          i_status
);
    localparam int BCNT_W = $clog2(SAMPLE_BITS + 1);
    localparam int NW     = lcar_pkg::CNT_W;
    localparam int WW     = lcar_pkg::WEIGHT_W;

    typedef enum logic [1:0] {S_RUN, S_DIV_READ, S_SUM_WAIT, S_DIV_AVG} t_state;
    typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_SHIFT, PH_EXTRA} t_phase;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic              r_clock_high, n_clock_high;
    logic [BCNT_W-1:0] r_bit_cnt, n_bit_cnt;
    logic [NW-1:0]     r_reads, n_reads;
    logic [1:0]        r_active, n_active;

    logic              r_item_valid, n_item_valid;
    logic              r_item_req, n_item_req;
    logic [1:0]        r_item_mode, n_item_mode;
    logic              r_item_data, n_item_data;

    logic              r_out_valid, n_out_valid;
    logic              r_out_clk, n_out_clk;
    logic              r_out_res, n_out_res;
    logic [WW-1:0]     r_out_weight, n_out_weight;
    logic              r_out_busy, n_out_busy;

    logic              w_out_free;
    logic              w_take;
    logic              w_accept;
    logic [NW-1:0]     w_reads_inc;
    lcar_pkg::t_dp_cmd w_cmd;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_take      = (r_state == S_RUN) && r_item_valid && w_out_free;
    assign o_in_stall  = r_item_valid && !w_take;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_reads_inc = r_reads + NW'(1);

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_clock_high = r_clock_high;
        n_bit_cnt    = r_bit_cnt;
        n_reads      = r_reads;
        n_active     = r_active;
        n_item_valid = r_item_valid;
        n_item_req   = r_item_req;
        n_item_mode  = r_item_mode;
        n_item_data  = r_item_data;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_clk    = r_out_clk;
        n_out_res    = r_out_res;
        n_out_weight = r_out_weight;
        n_out_busy   = r_out_busy;
        w_cmd           = '0;
        w_cmd.shift_bit = r_item_data;

        if (w_accept) begin
            n_item_valid = 1'b1;
            n_item_req   = i_req_type;
            n_item_mode  = i_mode;
            n_item_data  = i_data_level;
        end else if (w_take) begin
            n_item_valid = 1'b0;
        end

        unique case (r_state)
            S_RUN: begin
                if (w_take) begin
                    n_out_valid  = 1'b1;
                    n_out_res    = 1'b0;
                    n_out_weight = '0;
                    n_out_busy   = 1'b1;
                    n_out_clk    = 1'b0;
                    if (r_item_req == lcar_pkg::REQ_START) begin
                        if (r_phase == PH_IDLE) begin
                            n_active = (r_item_mode == lcar_pkg::MODE_RSV) ?
                                       lcar_pkg::MODE_READ : r_item_mode;
                            n_reads         = '0;
                            n_bit_cnt       = '0;
                            n_clock_high    = 1'b0;
                            n_phase         = PH_WAIT;
                            w_cmd.shift_clear = 1'b1;
                            w_cmd.sum_clear   = 1'b1;
                        end else begin
                            n_out_clk = r_clock_high;
                        end
                    end else begin
                        unique case (r_phase)
                            PH_IDLE: begin
                                n_clock_high = 1'b0;
                                n_out_busy   = 1'b0;
                            end
                            PH_WAIT: begin
                                if (!r_item_data) begin
                                    w_cmd.shift_clear = 1'b1;
                                    n_bit_cnt         = '0;
                                    n_clock_high      = 1'b0;
                                    n_phase           = PH_SHIFT;
                                end
                            end
                            PH_SHIFT: begin
                                if (!r_clock_high) begin
                                    n_out_clk      = 1'b1;
                                    w_cmd.shift_en = 1'b1;
                                    n_bit_cnt      = r_bit_cnt + BCNT_W'(1);
                                    n_clock_high   = 1'b1;
                                end else begin
                                    n_clock_high = 1'b0;
                                    if (r_bit_cnt >= BCNT_W'(SAMPLE_BITS)) begin
                                        n_phase = PH_EXTRA;
                                    end
                                end
                            end
                            PH_EXTRA: begin
                                if (!r_clock_high) begin
                                    n_out_clk    = 1'b1;
                                    n_clock_high = 1'b1;
                                end else begin
                                    n_clock_high = 1'b0;
                                    n_bit_cnt    = '0;
                                    if (r_active == lcar_pkg::MODE_TARE) begin
                                        w_cmd.tare_load = 1'b1;
                                        n_phase         = PH_IDLE;
                                        n_out_busy      = 1'b0;
                                    end else begin
                                        n_out_valid     = 1'b0;
                                        w_cmd.div_start = 1'b1;
                                        n_state         = S_DIV_READ;
                                    end
                                end
                            end
                            default: n_phase = PH_IDLE;
                        endcase
                    end
                end
            end
            S_DIV_READ: begin
                if (i_status.div_done) begin
                    n_out_clk = 1'b0;
                    if (r_active == lcar_pkg::MODE_AVG) begin
                        w_cmd.sum_add = 1'b1;
                        n_reads       = w_reads_inc;
                        if (w_reads_inc >= i_status.samples) begin
                            n_state = S_SUM_WAIT;
                        end else begin
                            n_out_valid  = 1'b1;
                            n_out_res    = 1'b0;
                            n_out_weight = '0;
                            n_out_busy   = 1'b1;
                            n_phase      = PH_WAIT;
                            n_state      = S_RUN;
                        end
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_res    = 1'b1;
                        n_out_weight = i_status.weight;
                        n_out_busy   = 1'b0;
                        n_phase      = PH_IDLE;
                        n_state      = S_RUN;
                    end
                end
            end
            S_SUM_WAIT: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_avg   = 1'b1;
                n_state         = S_DIV_AVG;
            end
            S_DIV_AVG: begin
                w_cmd.div_avg = 1'b1;
                if (i_status.div_done) begin
                    n_out_valid  = 1'b1;
                    n_out_clk    = 1'b0;
                    n_out_res    = 1'b1;
                    n_out_weight = i_status.weight;
                    n_out_busy   = 1'b0;
                    n_phase      = PH_IDLE;
                    n_state      = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_phase      <= PH_IDLE;
            r_clock_high <= 1'b0;
            r_bit_cnt    <= '0;
            r_reads      <= '0;
            r_active     <= lcar_pkg::MODE_READ;
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_clock_high <= n_clock_high;
            r_bit_cnt    <= n_bit_cnt;
            r_reads      <= n_reads;
            r_active     <= n_active;
            r_item_valid <= n_item_valid;
            r_out_valid  <= n_out_valid;
        end
        r_item_req   <= n_item_req;
        r_item_mode  <= n_item_mode;
        r_item_data  <= n_item_data;
        r_out_clk    <= n_out_clk;
        r_out_res    <= n_out_res;
        r_out_weight <= n_out_weight;
        r_out_busy   <= n_out_busy;
    end

    assign o_cmd          = w_cmd;
    assign o_out_valid    = r_out_valid;
    assign o_clock_level  = r_out_clk;
    assign o_result_valid = r_out_res;
    assign o_weight       = r_out_weight;
    assign o_busy_res     = r_out_busy;

endmodule

// ----- rtl/core/load_cell_adc_reader_core.sv -----
// Top level of the two-wire load-cell converter reader.
// Depends on lcar_pkg, lcar_ctrl and lcar_datapath.
//
// Usage:
//   Request channel (i_in_valid / o_in_stall): a start request picks read,
//   tare or averaged read; tick requests carry the sampled data line, one per
//   half period of the converter clock. Every request yields one result on
//   the result channel (o_out_valid / i_out_stall) with the clock level to
//   drive, a result flag, the weight and the busy flag.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0
//   calibration divisor, index 1 sample count; a zero value acts as 1.
// Timing (request handshake to result handshake):
//   Ordinary ticks and starts: one request per cycle sustained while the
//   result channel is not stalled and no divider pass runs. Last tick of a
//   read or of each averaged sample waits for the 32-step radix-2 divider;
//   last tick of an average waits for two divider passes. Tare needs none.
// Reset: tare offset 0, divisor 1, sample count 1, converter phase idle.
// Stall: one request is buffered; the result register holds until taken,
//   and further requests are stalled.
module load_cell_adc_reader_core #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [1:0]                        i_mode,
    input  logic                              i_data_level,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_clock_level,
    output logic                              o_result_valid,
    output logic signed [lcar_pkg::WEIGHT_W-1:0] o_weight,
    output logic                              o_busy_res,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [lcar_pkg::CAL_W-1:0]        i_cfg_data
);
    lcar_pkg::t_dp_cmd             w_cmd;
    lcar_pkg::t_dp_status          w_status;
    logic [lcar_pkg::WEIGHT_W-1:0] w_weight;

    lcar_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_mode         (i_mode),
        .i_data_level   (i_data_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_clock_level  (o_clock_level),
        .o_result_valid (o_result_valid),
        .o_weight       (w_weight),
        .o_busy_res     (o_busy_res),
        .o_cmd          (w_cmd),
        .i_status       (w_status)
    );

    lcar_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

    assign o_weight = signed'(w_weight);

endmodule

// ----- rtl/core/lcar_checker.sv -----
// Port-level checker for the load-cell converter reader, bound to the top.
// Depends on lcar_pkg for field widths.
module lcar_port_assert (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_clock_level,
    input logic                              o_result_valid,
    input logic signed [lcar_pkg::WEIGHT_W-1:0] o_weight,
    input logic                              o_busy_res
);
    localparam logic [lcar_pkg::WEIGHT_W-1:0] W_MIN = {1'b1, {(lcar_pkg::WEIGHT_W-1){1'b0}}};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_weight)
            && $stable(o_result_valid) && $stable(o_busy_res) && $stable(o_clock_level))
        else $error("stalled result changed");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_valid |-> !o_busy_res && !o_clock_level)
        else $error("result reported while busy");

    a_zero_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result_valid |-> o_weight == '0)
        else $error("weight nonzero without result");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_weight != W_MIN)
        else $error("weight out of range");

    a_clk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clock_level |-> o_busy_res)
        else $error("clock driven high while idle");

endmodule

bind load_cell_adc_reader_core lcar_port_assert u_lcar_port_assert (.*);

// ----- tb/lcar_checker.sv -----
// Result checker for load_cell_adc_reader_core: tracks register writes, predicts
// each result from the accepted requests and compares every field on delivery.
// Depends on lcar_pkg; instantiated by tb_top beside the block.
module lcar_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic                                 i_req_type,
    input  logic [1:0]                           i_mode,
    input  logic                                 i_data_level,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic                                 i_clock_level,
    input  logic                                 i_result_valid,
    input  logic signed [lcar_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                                 i_busy_res,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic                                 i_cfg_index,
    input  logic [lcar_pkg::CAL_W-1:0]           i_cfg_data,
    output int                                   o_errors,
    output int                                   o_pending,
    output logic                                 o_model_busy
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WEIGHT_W = lcar_pkg::WEIGHT_W;
    localparam int CAL_W    = lcar_pkg::CAL_W;
    localparam int CNT_W    = lcar_pkg::CNT_W;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_SHIFT,
        PH_EXTRA
    } t_phase;

    typedef struct packed {
        logic                clk_lvl;
        logic                res_vld;
        logic [WEIGHT_W-1:0] weight;
        logic                busy;
    } t_reading;

    localparam longint WEIGHT_LIM = longint'(lcar_pkg::WEIGHT_MAX);

    logic [CAL_W-1:0]       cal_div;
    logic [CNT_W-1:0]       smp_cnt;
    t_phase                 ph;
    logic [SAMPLE_BITS-1:0] shreg;
    logic [SAMPLE_BITS-1:0] tare_q;
    int                     nbits;
    logic                   clk_hi;
    longint                 acc;
    logic [CNT_W-1:0]       nreads;
    logic [1:0]             act_mode;
    t_reading               pending_readings[$];

    function automatic longint clamp_w(input longint v);
        if (v > WEIGHT_LIM) return WEIGHT_LIM;
        if (v < -WEIGHT_LIM) return -WEIGHT_LIM;
        return v;
    endfunction

    function automatic longint scale_raw(input logic [SAMPLE_BITS-1:0] raw);
        longint diff;
        longint dv;
        diff = longint'(raw) - longint'(tare_q);
        dv = (cal_div == '0) ? 64'sd1 : longint'(cal_div);
        return clamp_w(diff / dv);
    endfunction

    task automatic step_reader(input logic rq, input logic [1:0] md, input logic dl,
                               output t_reading r);
        longint w;
        longint n;
        r = '0;
        w = 0;
        if (rq == lcar_pkg::REQ_START) begin
            if (ph == PH_IDLE) begin
                act_mode = (md == lcar_pkg::MODE_RSV) ? lcar_pkg::MODE_READ : md;
                acc = 0;
                nreads = '0;
                shreg = '0;
                nbits = 0;
                clk_hi = 1'b0;
                ph = PH_WAIT;
            end
            r.clk_lvl = clk_hi;
        end else begin
            case (ph)
                PH_WAIT: begin
                    if (!dl) begin
                        shreg = '0;
                        nbits = 0;
                        clk_hi = 1'b0;
                        ph = PH_SHIFT;
                    end
                end
                PH_SHIFT: begin
                    if (!clk_hi) begin
                        r.clk_lvl = 1'b1;
                        shreg = {shreg[SAMPLE_BITS-2:0], dl};
                        nbits++;
                        clk_hi = 1'b1;
                    end else begin
                        clk_hi = 1'b0;
                        if (nbits >= SAMPLE_BITS) ph = PH_EXTRA;
                    end
                end
                PH_EXTRA: begin
                    if (!clk_hi) begin
                        r.clk_lvl = 1'b1;
                        clk_hi = 1'b1;
                    end else begin
                        clk_hi = 1'b0;
                        nbits = 0;
                        if (act_mode == lcar_pkg::MODE_TARE) begin
                            tare_q = shreg;
                            ph = PH_IDLE;
                        end else if (act_mode == lcar_pkg::MODE_AVG) begin
                            n = (smp_cnt == '0) ? 64'sd1 : longint'(smp_cnt);
                            acc += scale_raw(shreg);
                            nreads = nreads + 1'b1;
                            if (longint'(nreads) >= n) begin
                                w = clamp_w(acc / n);
                                r.res_vld = 1'b1;
                                ph = PH_IDLE;
                            end else begin
                                ph = PH_WAIT;
                            end
                        end else begin
                            w = scale_raw(shreg);
                            r.res_vld = 1'b1;
                            ph = PH_IDLE;
                        end
                    end
                end
                default: begin
                    clk_hi = 1'b0;
                    ph = PH_IDLE;
                end
            endcase
        end
        r.weight = w[WEIGHT_W-1:0];
        r.busy = (ph != PH_IDLE);
    endtask

    task automatic check_field(input string what, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_reading want;
        if (!i_rst_n) begin
            cal_div = CAL_W'(1);
            smp_cnt = CNT_W'(1);
            ph = PH_IDLE;
            shreg = '0;
            nbits = 0;
            clk_hi = 1'b0;
            tare_q = '0;
            acc = 0;
            nreads = '0;
            act_mode = lcar_pkg::MODE_READ;
            pending_readings.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == lcar_pkg::CFG_CAL) cal_div = i_cfg_data;
                else smp_cnt = i_cfg_data[CNT_W-1:0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_readings.size() == 0) begin
                    $display("%0t: result with no request pending, expected none, actual %0d",
                             $time, i_weight);
                    o_errors++;
                end else begin
                    want = pending_readings.pop_front();
                    check_field("clock_level", want.clk_lvl, i_clock_level);
                    check_field("result_valid", want.res_vld, i_result_valid);
                    check_field("weight", $signed(want.weight), i_weight);
                    check_field("busy_res", want.busy, i_busy_res);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                step_reader(i_req_type, i_mode, i_data_level, want);
                pending_readings.push_back(want);
            end
        end
        o_pending <= pending_readings.size();
        o_model_busy <= (ph != PH_IDLE);
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the load_cell_adc_reader_core testbench: clock, reset, request and
// register stimulus, result-side stalls and the verdict.
// Depends on lcar_pkg, load_cell_adc_reader_core and lcar_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS = 24;
    localparam int RAND_ITEMS  = 650;
    localparam int WEIGHT_W    = lcar_pkg::WEIGHT_W;
    localparam int CAL_W       = lcar_pkg::CAL_W;
    localparam int CNT_W       = lcar_pkg::CNT_W;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_req_type = lcar_pkg::REQ_TICK;
    logic [1:0]                 i_mode = lcar_pkg::MODE_READ;
    logic                       i_data_level = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic                       o_clock_level;
    logic                       o_result_valid;
    logic signed [WEIGHT_W-1:0] o_weight;
    logic                       o_busy_res;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic                       i_cfg_index = lcar_pkg::CFG_CAL;
    logic [CAL_W-1:0]           i_cfg_data = '0;

    int               err_cnt;
    int               pend_cnt;
    logic             model_busy;
    bit               calm = 1'b0;
    bit               quiet = 1'b0;
    bit               hold_go = 1'b0;
    bit               hold_done = 1'b0;
    logic [CNT_W-1:0] cur_cnt = CNT_W'(1);
    int               rnd_items = 0;

    load_cell_adc_reader_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_mode         (i_mode),
        .i_data_level   (i_data_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_clock_level  (o_clock_level),
        .o_result_valid (o_result_valid),
        .o_weight       (o_weight),
        .o_busy_res     (o_busy_res),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    lcar_checker #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_mode         (i_mode),
        .i_data_level   (i_data_level),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_clock_level  (o_clock_level),
        .i_result_valid (o_result_valid),
        .i_weight       (o_weight),
        .i_busy_res     (o_busy_res),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (err_cnt),
        .o_pending      (pend_cnt),
        .o_model_busy   (model_busy)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("load_cell_adc_reader_core verification failed");
        $finish;
    end

    // Leaves valid high on return so back-to-back requests need no gap.
    task automatic push_req(input logic rq, input logic [1:0] md, input logic dl);
        if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= rq;
        i_mode       <= md;
        i_data_level <= dl;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic feed_tick(input logic dl, input bit poke);
        if (poke && $urandom_range(0, 40) == 0)
            push_req(lcar_pkg::REQ_START, 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)));
        push_req(lcar_pkg::REQ_TICK, 2'($urandom_range(0, 3)), dl);
        rnd_items++;
    endtask

    task automatic measure(input logic [1:0] md, input int pat, input bit poke);
        int                     reads;
        logic [SAMPLE_BITS-1:0] raw;
        reads = (md == lcar_pkg::MODE_AVG && cur_cnt != '0) ? int'(cur_cnt) : 1;
        push_req(lcar_pkg::REQ_START, md, 1'($urandom_range(0, 1)));
        if (poke) begin
            push_req(lcar_pkg::REQ_START, lcar_pkg::MODE_READ, 1'b0);
            push_req(lcar_pkg::REQ_START, lcar_pkg::MODE_TARE, 1'b1);
            push_req(lcar_pkg::REQ_START, lcar_pkg::MODE_AVG, 1'b0);
        end
        repeat (reads) begin
            if (pat == 0) raw = '0;
            else if (pat == 1) raw = '1;
            else raw = SAMPLE_BITS'($urandom);
            repeat ($urandom_range(0, 4)) feed_tick(1'b1, poke);
            feed_tick(1'b0, poke);
            for (int b = SAMPLE_BITS - 1; b >= 0; b--) begin
                feed_tick(raw[b], poke);
                feed_tick(1'($urandom_range(0, 1)), poke);
            end
            feed_tick(1'($urandom_range(0, 1)), poke);
            feed_tick(1'($urandom_range(0, 1)), poke);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pend_cnt != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [CAL_W-1:0] cal, input logic [CNT_W-1:0] cnt);
        logic [CAL_W-1:0] junk;
        junk = CAL_W'($urandom);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= lcar_pkg::CFG_CAL;
        i_cfg_data  <= cal;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= lcar_pkg::CFG_SAMPLES;
        i_cfg_data  <= {junk[CAL_W-1:CNT_W], cnt};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_cnt = cnt;
    endtask

    initial begin : result_stall
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (80) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_done <= 1'b1;
            end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int               phase_no;
        int               pick;
        logic [CAL_W-1:0] cal;
        logic [CNT_W-1:0] cnt;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_req(lcar_pkg::REQ_TICK, lcar_pkg::MODE_READ, 1'b0);
        push_req(lcar_pkg::REQ_TICK, lcar_pkg::MODE_RSV, 1'b1);
        measure(lcar_pkg::MODE_RSV, 1, 1'b1);
        measure(lcar_pkg::MODE_TARE, 1, 1'b0);
        measure(lcar_pkg::MODE_READ, 0, 1'b0);
        settle();

        rnd_items = 0;
        phase_no = 0;
        while (rnd_items < RAND_ITEMS) begin
            case (phase_no)
                0: begin
                    cal = '0;
                    cnt = '0;
                end
                1: begin
                    cal = lcar_pkg::WEIGHT_MAX;
                    cnt = CNT_W'(3);
                end
                2: begin
                    cal = CAL_W'(1);
                    cnt = CNT_W'(8);
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0: cal = CAL_W'(1);
                        1: cal = '0;
                        2: cal = lcar_pkg::WEIGHT_MAX;
                        3: cal = CAL_W'($urandom_range(1, 255));
                        4: cal = CAL_W'($urandom_range(256, 65535));
                        default: cal = CAL_W'($urandom);
                    endcase
                    case ($urandom_range(0, 4))
                        0: cnt = CNT_W'(1);
                        1: cnt = '0;
                        default: cnt = CNT_W'($urandom_range(2, 6));
                    endcase
                end
            endcase
            set_regs(cal, cnt);
            quiet <= ($urandom_range(0, 3) == 0);
            if (phase_no == 1) hold_go <= 1'b1;
            if (phase_no == 0) measure(lcar_pkg::MODE_AVG, 2, 1'b0);
            if (phase_no == 2) begin
                measure(lcar_pkg::MODE_AVG, 2, 1'b0);
            end else begin
                repeat ($urandom_range(2, 5)) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 2) begin
                        repeat ($urandom_range(5, 15))
                            push_req(($urandom_range(0, 2) == 0) ? lcar_pkg::REQ_START
                                                                 : lcar_pkg::REQ_TICK,
                                     2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                        // drain back to idle before the next request sequence
                        i_in_valid <= 1'b0;
                        @(posedge i_clk);
                        while (model_busy) begin
                            push_req(lcar_pkg::REQ_TICK, 2'($urandom_range(0, 3)),
                                     $urandom_range(0, 3) == 0);
                            i_in_valid <= 1'b0;
                            @(posedge i_clk);
                        end
                    end else begin
                        measure((pick < 9) ? lcar_pkg::MODE_READ :
                                (pick < 13) ? lcar_pkg::MODE_TARE :
                                (pick < 19) ? lcar_pkg::MODE_AVG : lcar_pkg::MODE_RSV,
                                ($urandom_range(0, 6) == 0) ? 0 :
                                ($urandom_range(0, 5) == 0) ? 1 : 2,
                                $urandom_range(0, 4) == 0);
                    end
                end
            end
            settle();
            phase_no++;
        end

        calm <= 1'b1;
        @(posedge i_clk);
        measure(lcar_pkg::MODE_READ, 2, 1'b0);
        measure(lcar_pkg::MODE_AVG, 2, 1'b0);
        settle();
        repeat (100) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("load_cell_adc_reader_core verification clean");
        end else begin
            $display("load_cell_adc_reader_core verification failed");
        end
        $finish;
    end

endmodule
